// ===== hdl/i2cbs_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package i2cbs_pkg;

	// Raw function codes on the func port
	localparam logic [2:0] FUNC_NONE     = 3'd0;
	localparam logic [2:0] FUNC_START    = 3'd1;
	localparam logic [2:0] FUNC_STOP     = 3'd2;
	localparam logic [2:0] FUNC_WRITE    = 3'd3;
	localparam logic [2:0] FUNC_READ     = 3'd4;
	localparam logic [2:0] FUNC_WAIT_ACK = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 8'd1;

	// Register reset values and bit constants
	localparam logic [7:0] UNIT_TICKS_RESET  = 8'd1;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
	localparam logic [7:0] MSB_MASK          = 8'h80;
	localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

	// Classified command
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ,
		CMD_WAIT_ACK
	} cmd_t;

	// One classified tick item, as queued between front and back
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_line;
		logic       scl_line;
	} item_t;

	// Configuration registers seen by the back end
	typedef struct packed {
		logic [7:0] unit_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} result_t;

endpackage

// ===== hdl/i2cbs_front.sv =====
// Front end of the I2C master bit sequencer: classifies the raw func code.
// Depends on i2cbs_pkg.
`timescale 1ns / 1ps

module i2cbs_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        func,
	input  logic [7:0]        tx_byte,
	input  logic              send_ack,
	input  logic              sda_line,
	input  logic              scl_line,
	output logic              push_valid,
	input  logic              push_ready,
	output i2cbs_pkg::item_t  push_item
);
	import i2cbs_pkg::*;

	cmd_t cmd;

	// Map func codes onto commands; unused codes do nothing
	always_comb begin
		unique case (func)
			FUNC_START:    cmd = CMD_START;
			FUNC_STOP:     cmd = CMD_STOP;
			FUNC_WRITE:    cmd = CMD_WRITE;
			FUNC_READ:     cmd = CMD_READ;
			FUNC_WAIT_ACK: cmd = CMD_WAIT_ACK;
			default:       cmd = CMD_NONE;
		endcase
	end

	// Pass the handshake straight to the queue
	assign push_valid         = in_valid;
	assign in_ready           = push_ready;
	assign push_item.cmd      = cmd;
	assign push_item.tx_byte  = tx_byte;
	assign push_item.send_ack = send_ack;
	assign push_item.sda_line = sda_line;
	assign push_item.scl_line = scl_line;

endmodule

// ===== hdl/i2cbs_queue.sv =====
// Two-entry item queue between the front and back ends.
// Depends on i2cbs_pkg.
`timescale 1ns / 1ps

module i2cbs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  i2cbs_pkg::item_t push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output i2cbs_pkg::item_t pop_item
);
	import i2cbs_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/i2cbs_back.sv =====
// Back end of the I2C master bit sequencer: runs one sequencer step per item
// and holds the result in an output register. Depends on i2cbs_pkg.
`timescale 1ns / 1ps

module i2cbs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  i2cbs_pkg::cfg_t    cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  i2cbs_pkg::item_t   pop_item,
	output logic               out_valid,
	input  logic               out_ready,
	output i2cbs_pkg::result_t result
);
	import i2cbs_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C,
		PH_W_LOW, PH_W_HIGH, PH_W_AFTER, PH_W_GAP, PH_CK_SET, PH_CK_HIGH,
		PH_R_LOW, PH_R_HIGH, PH_R_HOLD, PH_A_REL, PH_A_HIGH, PH_A_POLL, PH_A_LOW
	} phase_t;

	// Step length of each phase in delay units; zero means one tick
	function automatic logic [2:0] step_len(input phase_t ph);
		logic [2:0] len;
		unique case (ph)
			PH_ST_A, PH_CK_HIGH:                      len = 3'd5;
			PH_ST_B, PH_SP_B, PH_SP_C:                len = 3'd6;
			PH_W_HIGH, PH_W_AFTER, PH_W_GAP,
			PH_CK_SET, PH_R_LOW:                      len = 3'd2;
			PH_W_LOW, PH_R_HOLD, PH_A_REL,
			PH_A_HIGH, PH_A_LOW:                      len = 3'd1;
			default:                                  len = 3'd0;
		endcase
		return len;
	endfunction

	phase_t     phase_q;
	cmd_t       active_q;
	logic [3:0] bit_idx_q;
	logic [7:0] shift_q;
	logic [2:0] unit_q;
	logic [7:0] pre_q;
	logic [7:0] wait_q;
	logic       ack_choice_q;
	logic       scl_q;
	logic       sda_q;
	logic [7:0] rx_q;
	logic       fail_q;
	logic       out_valid_q;
	result_t    result_q;

	phase_t     n_phase;
	cmd_t       n_active;
	logic [3:0] n_bit_idx;
	logic [7:0] n_shift;
	logic [2:0] n_unit;
	logic [7:0] n_pre;
	logic [7:0] n_wait;
	logic       n_ack_choice;
	logic       n_scl;
	logic       n_sda;
	logic [7:0] n_rx;
	logic       n_fail;
	logic       n_done;

	logic       go;
	phase_t     go_phase;
	logic       go_scl;
	logic       go_sda;

	logic [2:0] len;
	logic [7:0] pre_plus;
	logic       tick;
	logic [7:0] pre_inc;
	logic [2:0] unit_inc;
	logic       over;
	logic       bit_out;
	logic       ack_lvl;
	logic [3:0] bit_next;
	logic [8:0] wait_next;
	logic       step;

	// Pop an item whenever the output register is free or being drained
	assign pop_ready = !out_valid_q || out_ready;
	assign step      = pop_valid && pop_ready;

	// Shared unit and step timing
	always_comb begin
		len       = step_len(phase_q);
		pre_plus  = pre_q + 8'd1;
		tick      = (pre_plus == cfg.unit_ticks);
		pre_inc   = tick ? 8'd0 : pre_plus;
		unit_inc  = tick ? unit_q + 3'd1 : unit_q;
		over      = (len == 3'd0) || (unit_inc >= len);
		bit_out   = |(shift_q & MSB_MASK);
		ack_lvl   = ~ack_choice_q;
		bit_next  = bit_idx_q + 4'd1;
		wait_next = {1'b0, wait_q} + 9'd1;
	end

	// Compute the next sequencer state for one tick
	always_comb begin
		n_phase      = phase_q;
		n_active     = active_q;
		n_bit_idx    = bit_idx_q;
		n_shift      = shift_q;
		n_unit       = unit_q;
		n_pre        = pre_q;
		n_wait       = wait_q;
		n_ack_choice = ack_choice_q;
		n_scl        = scl_q;
		n_sda        = sda_q;
		n_rx         = rx_q;
		n_fail       = fail_q;
		n_done       = 1'b0;
		go           = 1'b0;
		go_phase     = phase_q;
		go_scl       = scl_q;
		go_sda       = sda_q;

		if (phase_q == PH_IDLE) begin
			// Accept a new command
			if (pop_item.cmd != CMD_NONE) begin
				n_active     = pop_item.cmd;
				n_bit_idx    = 4'd0;
				n_wait       = 8'd0;
				n_ack_choice = 1'b0;
				go           = 1'b1;
				unique case (pop_item.cmd)
					CMD_START: begin
						go_phase = PH_ST_A; go_scl = 1'b1; go_sda = 1'b1;
					end
					CMD_STOP: begin
						go_phase = PH_SP_A; go_scl = 1'b0; go_sda = 1'b0;
					end
					CMD_WRITE: begin
						n_shift  = pop_item.tx_byte;
						go_phase = PH_W_LOW; go_scl = 1'b0;
						go_sda   = |(pop_item.tx_byte & MSB_MASK);
					end
					CMD_READ: begin
						n_shift      = 8'd0;
						n_ack_choice = pop_item.send_ack;
						go_phase     = PH_R_LOW; go_scl = 1'b0; go_sda = 1'b1;
					end
					default: begin
						go_phase = PH_A_REL; go_scl = scl_q; go_sda = 1'b1;
					end
				endcase
			end
		end else begin
			// Count the step timer where the phase has a length
			if (len != 3'd0) begin
				n_pre  = pre_inc;
				n_unit = unit_inc;
			end
			unique case (phase_q)
				PH_ST_A: if (over) begin
					go = 1'b1; go_phase = PH_ST_B; go_scl = 1'b1; go_sda = 1'b0;
				end
				PH_ST_B: if (over) begin
					n_done = 1'b1;
					go = 1'b1; go_phase = PH_IDLE; go_scl = 1'b0; go_sda = 1'b0;
				end
				PH_SP_A: if (over) begin
					go = 1'b1; go_phase = PH_SP_B; go_scl = 1'b1; go_sda = 1'b0;
				end
				PH_SP_B: if (over) begin
					go = 1'b1; go_phase = PH_SP_C; go_scl = 1'b1; go_sda = 1'b1;
				end
				PH_SP_C: if (over) begin
					if (active_q == CMD_WAIT_ACK) n_fail = 1'b1;
					n_done = 1'b1;
					go = 1'b1; go_phase = PH_IDLE; go_scl = 1'b1; go_sda = 1'b1;
				end
				PH_W_LOW: if (over) begin
					go = 1'b1; go_phase = PH_W_HIGH; go_scl = 1'b1; go_sda = bit_out;
				end
				PH_W_HIGH: if (over) begin
					go = 1'b1; go_phase = PH_W_AFTER; go_scl = 1'b0; go_sda = bit_out;
				end
				PH_W_AFTER: if (over) begin
					n_bit_idx = bit_next;
					go        = 1'b1;
					go_scl    = 1'b0;
					if (bit_next >= BITS_PER_BYTE) begin
						go_phase = PH_W_GAP; go_sda = bit_out;
					end else begin
						n_shift  = {shift_q[6:0], 1'b0};
						go_phase = PH_W_LOW; go_sda = shift_q[6];
					end
				end
				PH_W_GAP: if (over) begin
					go = 1'b1; go_phase = PH_CK_SET; go_scl = 1'b0; go_sda = ack_lvl;
				end
				PH_CK_SET: if (over) begin
					go = 1'b1; go_phase = PH_CK_HIGH; go_scl = 1'b1; go_sda = ack_lvl;
				end
				PH_CK_HIGH: if (over) begin
					if (active_q == CMD_READ) n_rx = shift_q;
					n_done = 1'b1;
					go = 1'b1; go_phase = PH_IDLE; go_scl = 1'b0; go_sda = ack_lvl;
				end
				PH_R_LOW: if (over) begin
					go = 1'b1; go_phase = PH_R_HIGH; go_scl = 1'b1; go_sda = 1'b1;
				end
				PH_R_HIGH: if (pop_item.scl_line) begin
					// Sample only once SCL is seen high
					n_shift = {shift_q[6:0], pop_item.sda_line};
					go = 1'b1; go_phase = PH_R_HOLD; go_scl = 1'b1; go_sda = 1'b1;
				end
				PH_R_HOLD: if (over) begin
					n_bit_idx = bit_next;
					go        = 1'b1;
					go_scl    = 1'b0;
					if (bit_next >= BITS_PER_BYTE) begin
						go_phase = PH_CK_SET; go_sda = ack_lvl;
					end else begin
						go_phase = PH_R_LOW; go_sda = 1'b1;
					end
				end
				PH_A_REL: if (over) begin
					go = 1'b1; go_phase = PH_A_HIGH; go_scl = 1'b1; go_sda = 1'b1;
				end
				PH_A_HIGH: if (over) begin
					n_wait = 8'd0;
					go = 1'b1; go_phase = PH_A_POLL; go_scl = 1'b1; go_sda = 1'b1;
				end
				PH_A_POLL: begin
					if (!pop_item.sda_line) begin
						go = 1'b1; go_phase = PH_A_LOW; go_scl = 1'b0; go_sda = 1'b1;
					end else begin
						// Count timeout units while SDA stays high
						n_pre = pre_inc;
						if (tick) begin
							if (wait_next > {1'b0, cfg.ack_timeout}) begin
								go = 1'b1; go_phase = PH_SP_A; go_scl = 1'b0; go_sda = 1'b0;
							end else begin
								n_wait = wait_next[7:0];
							end
						end
					end
				end
				PH_A_LOW: if (over) begin
					n_fail = 1'b0;
					n_done = 1'b1;
					go = 1'b1; go_phase = PH_IDLE; go_scl = 1'b0; go_sda = 1'b1;
				end
				default: begin
					n_done = 1'b1;
					go = 1'b1; go_phase = PH_IDLE; go_scl = scl_q; go_sda = sda_q;
				end
			endcase
		end

		// Enter the next phase with a fresh step timer
		if (go) begin
			n_phase = go_phase;
			n_scl   = go_scl;
			n_sda   = go_sda;
			n_unit  = 3'd0;
			n_pre   = 8'd0;
		end
	end

	// Hold sequencer state and the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			active_q     <= CMD_NONE;
			bit_idx_q    <= 4'd0;
			shift_q      <= 8'd0;
			unit_q       <= 3'd0;
			pre_q        <= 8'd0;
			wait_q       <= 8'd0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			rx_q         <= 8'd0;
			fail_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (step) begin
				phase_q      <= n_phase;
				active_q     <= n_active;
				bit_idx_q    <= n_bit_idx;
				shift_q      <= n_shift;
				unit_q       <= n_unit;
				pre_q        <= n_pre;
				wait_q       <= n_wait;
				ack_choice_q <= n_ack_choice;
				scl_q        <= n_scl;
				sda_q        <= n_sda;
				rx_q         <= n_rx;
				fail_q       <= n_fail;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// Load the result payload with each step
	always_ff @(posedge clk) begin
		if (step) begin
			result_q.scl_drive  <= n_scl;
			result_q.sda_drive  <= n_sda;
			result_q.busy_res   <= (n_phase != PH_IDLE);
			result_q.done_res   <= n_done;
			result_q.rx_byte    <= n_rx;
			result_q.ack_failed <= n_fail;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ===== hdl/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: one tick item in, one result item out.
// A result is registered: an accepted item is first written into the queue,
// then a sequencer step loads its result into the output register.
// Throughput: one item per cycle while out_ready keeps the output register drained.
// Reset: asynchronous, clears the queue, the output valid flag, the sequencer
// (idle, both lines released) and loads the register reset values.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        func,
	input  logic [7:0]                        tx_byte,
	input  logic                              send_ack,
	input  logic                              sda_line,
	input  logic                              scl_line,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              scl_drive,
	output logic                              sda_drive,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [7:0]                        rx_byte,
	output logic                              ack_failed,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [i2cbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                        cfg_data
);
	import i2cbs_pkg::*;

	cfg_t    cfg_q;
	logic    push_valid;
	logic    push_ready;
	item_t   push_item;
	logic    pop_valid;
	logic    pop_ready;
	item_t   pop_item;
	result_t result;

	// Take configuration writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_ticks  <= UNIT_TICKS_RESET;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_UNIT_TICKS:  cfg_q.unit_ticks  <= cfg_data;
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	i2cbs_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.tx_byte    (tx_byte),
		.send_ack   (send_ack),
		.sda_line   (sda_line),
		.scl_line   (scl_line),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	i2cbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	i2cbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

	assign scl_drive  = result.scl_drive;
	assign sda_drive  = result.sda_drive;
	assign busy_res   = result.busy_res;
	assign done_res   = result.done_res;
	assign rx_byte    = result.rx_byte;
	assign ack_failed = result.ack_failed;

endmodule
